// ===== hw/rtl/spdlq_pkg.sv =====
// Package for the shared-pool dual-list queue: sizes, operation codes,
// transaction layouts and the structs passed between the block's modules.
// No dependencies.
package spdlq_pkg;

	localparam int POOL_SLOTS = 16;
	localparam int HANDLE_W   = 16;
	localparam int SLOT_W     = $clog2(POOL_SLOTS);
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

	typedef enum logic [2:0] {
		MODE_PUSH_TX  = 3'd0,
		MODE_PUSH_RX  = 3'd1,
		MODE_FIRST_TX = 3'd2,
		MODE_FIRST_RX = 3'd3,
		MODE_NEXT     = 3'd4,
		MODE_REMOVE   = 3'd5,
		MODE_READ     = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FETCH,
		ST_HOLD
	} state_t;

	// input transaction, first field in the highest bits
	typedef struct packed {
		logic                cursor_present;
		logic [SLOT_W-1:0]   cursor_slot;
		logic [HANDLE_W-1:0] frame_handle;
		mode_t               mode;
	} in_item_t;

	// result transaction, first field in the highest bits
	typedef struct packed {
		logic [CNT_W-1:0]    slots_free;
		logic [CNT_W-1:0]    rx_used;
		logic [CNT_W-1:0]    tx_used;
		logic [HANDLE_W-1:0] frame_out;
		logic                slot_found;
		logic [SLOT_W-1:0]   result_slot;
		logic                success;
	} result_t;

	localparam int IN_W  = (($bits(in_item_t) + 7) / 8) * 8;
	localparam int OUT_W = (($bits(result_t) + 7) / 8) * 8;

	// per-slot flag updates from the sequencer
	typedef struct packed {
		logic              set_en;
		logic [SLOT_W-1:0] set_slot;
		logic              set_rx;
		logic              set_hn;
		logic              clr_en;
		logic [SLOT_W-1:0] clr_slot;
		logic              hn_en;
		logic [SLOT_W-1:0] hn_slot;
		logic              hn_val;
	} flag_cmd_t;

	// per-slot flags and the lowest free slot
	typedef struct packed {
		logic [POOL_SLOTS-1:0] busy;
		logic [POOL_SLOTS-1:0] in_rx;
		logic [POOL_SLOTS-1:0] has_next;
		logic                  free_found;
		logic [SLOT_W-1:0]     free_slot;
	} flag_view_t;

	// one write and one read port of a link memory
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [SLOT_W-1:0] wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} link_port_t;

	// one write and one read port of the handle memory
	typedef struct packed {
		logic                we;
		logic [SLOT_W-1:0]   waddr;
		logic [HANDLE_W-1:0] wdata;
		logic                re;
		logic [SLOT_W-1:0]   raddr;
	} frame_port_t;

endpackage

// ===== hw/rtl/spdlq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module spdlq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/spdlq_flags.sv =====
// Per-slot busy, receive-list and has-next flags with the lowest free slot finder.
// Depends on spdlq_pkg.
module spdlq_flags (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spdlq_pkg::flag_cmd_t   cmd,
	output spdlq_pkg::flag_view_t  view
);
	import spdlq_pkg::*;

	logic [POOL_SLOTS-1:0] busy_q;
	logic [POOL_SLOTS-1:0] in_rx_q;
	logic [POOL_SLOTS-1:0] has_next_q;
	logic                  free_found;
	logic [SLOT_W-1:0]     free_slot;

	// apply link flag update, then slot claim, then slot release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			in_rx_q    <= '0;
			has_next_q <= '0;
		end else begin
			if (cmd.hn_en) begin
				has_next_q[cmd.hn_slot] <= cmd.hn_val;
			end
			if (cmd.set_en) begin
				busy_q[cmd.set_slot]     <= 1'b1;
				in_rx_q[cmd.set_slot]    <= cmd.set_rx;
				has_next_q[cmd.set_slot] <= cmd.set_hn;
			end
			if (cmd.clr_en) begin
				busy_q[cmd.clr_slot]     <= 1'b0;
				in_rx_q[cmd.clr_slot]    <= 1'b0;
				has_next_q[cmd.clr_slot] <= 1'b0;
			end
		end
	end

	// find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
		end
	end

	assign view.busy       = busy_q;
	assign view.in_rx      = in_rx_q;
	assign view.has_next   = has_next_q;
	assign view.free_found = free_found;
	assign view.free_slot  = free_slot;

endmodule

// ===== hw/rtl/spdlq_ctrl.sv =====
// Operation sequencer: list heads and counts, memory read-modify-write of the
// link and handle memories, and result assembly. Depends on spdlq_pkg.
module spdlq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  spdlq_pkg::in_item_t        in_item,
	input  logic                       out_free,
	output logic                       res_valid,
	output spdlq_pkg::result_t         res,
	input  spdlq_pkg::flag_view_t      flags,
	output spdlq_pkg::flag_cmd_t       flag_cmd,
	output spdlq_pkg::frame_port_t     frame_port,
	input  logic [spdlq_pkg::HANDLE_W-1:0] frame_rd,
	output spdlq_pkg::link_port_t      next_port,
	input  logic [spdlq_pkg::SLOT_W-1:0]   next_rd,
	output spdlq_pkg::link_port_t      prev_port,
	input  logic [spdlq_pkg::SLOT_W-1:0]   prev_rd
);
	import spdlq_pkg::*;

	state_t              state_q, state_d;
	mode_t               mode_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SLOT_W-1:0]   cursor_q;
	logic                cur_ok_q;
	logic [SLOT_W-1:0]   nslot_q;
	result_t             res_q, res_d;
	logic [SLOT_W-1:0]   tx_head_q, rx_head_q, tx_head_d, rx_head_d;
	logic [CNT_W-1:0]    tx_cnt_q, rx_cnt_q, tx_cnt_d, rx_cnt_d;
	logic                accept;
	logic                cur_ok_in;
	logic                go_fetch;
	logic                sel_rx;
	logic [SLOT_W-1:0]   head_sel, new_head;
	logic [CNT_W-1:0]    cnt_sel;
	logic                hn;

	assign accept    = in_valid && in_ready;
	assign cur_ok_in = in_item.cursor_present
		&& ({1'b0, in_item.cursor_slot} < (SLOT_W + 1)'(POOL_SLOTS))
		&& flags.busy[in_item.cursor_slot];

	// latch the transaction and the cursor check
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_item.mode;
			handle_q <= in_item.frame_handle;
			cursor_q <= in_item.cursor_slot;
			cur_ok_q <= cur_ok_in;
		end
		if (state_q == ST_EXEC) begin
			nslot_q <= next_rd;
		end
		if (state_q == ST_EXEC || state_q == ST_FETCH) begin
			res_q <= res_d;
		end
	end

	// state, heads and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tx_head_q <= '0;
			rx_head_q <= '0;
			tx_cnt_q  <= '0;
			rx_cnt_q  <= '0;
		end else begin
			state_q   <= state_d;
			tx_head_q <= tx_head_d;
			rx_head_q <= rx_head_d;
			tx_cnt_q  <= tx_cnt_d;
			rx_cnt_q  <= rx_cnt_d;
		end
	end

	// memory accesses, flag updates and result of the current step
	always_comb begin
		frame_port = '0;
		next_port  = '0;
		prev_port  = '0;
		flag_cmd   = '0;
		res_d      = '0;
		go_fetch   = 1'b0;
		tx_head_d  = tx_head_q;
		rx_head_d  = rx_head_q;
		tx_cnt_d   = tx_cnt_q;
		rx_cnt_d   = rx_cnt_q;
		sel_rx     = 1'b0;
		head_sel   = tx_head_q;
		cnt_sel    = tx_cnt_q;
		new_head   = tx_head_q;
		hn         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// start reads for the slot the operation addresses
				frame_port.re = accept;
				next_port.re  = accept;
				prev_port.re  = accept;
				next_port.raddr = in_item.cursor_slot;
				prev_port.raddr = in_item.cursor_slot;
				case (in_item.mode)
					MODE_FIRST_TX: frame_port.raddr = tx_head_q;
					MODE_FIRST_RX: frame_port.raddr = rx_head_q;
					default:       frame_port.raddr = in_item.cursor_slot;
				endcase
			end
			ST_EXEC: begin
				case (mode_q)
					MODE_PUSH_TX, MODE_PUSH_RX: begin
						sel_rx   = (mode_q == MODE_PUSH_RX);
						head_sel = sel_rx ? rx_head_q : tx_head_q;
						cnt_sel  = sel_rx ? rx_cnt_q : tx_cnt_q;
						if (flags.free_found) begin
							// store handle and link new slot in front of the head
							frame_port.we    = 1'b1;
							frame_port.waddr = flags.free_slot;
							frame_port.wdata = handle_q;
							next_port.we     = 1'b1;
							next_port.waddr  = flags.free_slot;
							next_port.wdata  = (cnt_sel != '0) ? head_sel : '0;
							prev_port.we     = (cnt_sel != '0);
							prev_port.waddr  = head_sel;
							prev_port.wdata  = flags.free_slot;
							flag_cmd.set_en   = 1'b1;
							flag_cmd.set_slot = flags.free_slot;
							flag_cmd.set_rx   = sel_rx;
							flag_cmd.set_hn   = (cnt_sel != '0);
							if (sel_rx) begin
								rx_head_d = flags.free_slot;
								rx_cnt_d  = rx_cnt_q + CNT_W'(1);
							end else begin
								tx_head_d = flags.free_slot;
								tx_cnt_d  = tx_cnt_q + CNT_W'(1);
							end
							res_d.success = 1'b1;
						end
					end
					MODE_FIRST_TX, MODE_FIRST_RX: begin
						sel_rx   = (mode_q == MODE_FIRST_RX);
						head_sel = sel_rx ? rx_head_q : tx_head_q;
						cnt_sel  = sel_rx ? rx_cnt_q : tx_cnt_q;
						if (cnt_sel != '0) begin
							res_d.success     = 1'b1;
							res_d.slot_found  = 1'b1;
							res_d.result_slot = head_sel;
							res_d.frame_out   = frame_rd;
						end
					end
					MODE_NEXT: begin
						// follow the link, then read the handle of the next slot
						if (cur_ok_q && flags.has_next[cursor_q]) begin
							go_fetch         = 1'b1;
							frame_port.re    = 1'b1;
							frame_port.raddr = next_rd;
						end
					end
					MODE_REMOVE: begin
						if (cur_ok_q) begin
							sel_rx   = flags.in_rx[cursor_q];
							head_sel = sel_rx ? rx_head_q : tx_head_q;
							cnt_sel  = sel_rx ? rx_cnt_q : tx_cnt_q;
							hn       = flags.has_next[cursor_q];
							new_head = head_sel;
							// unlink from the head or from the previous slot
							if (head_sel == cursor_q) begin
								new_head = hn ? next_rd : '0;
							end else begin
								next_port.we    = 1'b1;
								next_port.waddr = prev_rd;
								next_port.wdata = next_rd;
								flag_cmd.hn_en   = 1'b1;
								flag_cmd.hn_slot = prev_rd;
								flag_cmd.hn_val  = hn;
							end
							prev_port.we    = hn;
							prev_port.waddr = next_rd;
							prev_port.wdata = (new_head == next_rd) ? '0 : prev_rd;
							flag_cmd.clr_en   = 1'b1;
							flag_cmd.clr_slot = cursor_q;
							if (sel_rx) begin
								rx_head_d = new_head;
								if (rx_cnt_q != '0) begin
									rx_cnt_d = rx_cnt_q - CNT_W'(1);
								end
							end else begin
								tx_head_d = new_head;
								if (tx_cnt_q != '0) begin
									tx_cnt_d = tx_cnt_q - CNT_W'(1);
								end
							end
							res_d.success   = 1'b1;
							res_d.frame_out = frame_rd;
						end
					end
					MODE_READ: begin
						if (cur_ok_q) begin
							res_d.success   = 1'b1;
							res_d.frame_out = frame_rd;
						end
					end
					default: begin
					end
				endcase
			end
			ST_FETCH: begin
				res_d.success     = 1'b1;
				res_d.slot_found  = 1'b1;
				res_d.result_slot = nslot_q;
				res_d.frame_out   = frame_rd;
			end
			default: begin
			end
		endcase
		// report counts after the operation
		res_d.tx_used    = tx_cnt_d;
		res_d.rx_used    = rx_cnt_d;
		res_d.slots_free = CNT_W'(POOL_SLOTS) - tx_cnt_d - rx_cnt_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (go_fetch) begin
					state_d = ST_FETCH;
				end else begin
					state_d = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_FETCH: state_d = out_free ? ST_IDLE : ST_HOLD;
			ST_HOLD:  state_d = out_free ? ST_IDLE : ST_HOLD;
			default:  state_d = ST_IDLE;
		endcase
	end

	// handshake and result outputs
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res       = res_d;
		case (state_q)
			ST_IDLE:  in_ready  = 1'b1;
			ST_EXEC:  res_valid = !go_fetch;
			ST_FETCH: res_valid = 1'b1;
			ST_HOLD: begin
				res_valid = 1'b1;
				res       = res_q;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/shared_pool_dual_list_queue.sv =====
// Shared-pool dual-list queue: transmit and receive lists over one slot pool.
// Each operation reads the handle and link memories when accepted and writes them back
// in the exec state (a next that finds a slot reads the handle again in the fetch
// state); the result is registered at the output, and no new input is taken meanwhile.
// Reset: asynchronous, clears flags, heads, counts and handshake; memories keep contents.
// Depends on spdlq_pkg, spdlq_ram, spdlq_flags, spdlq_ctrl.
module shared_pool_dual_list_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// mode[2:0], frame_handle[18:3], cursor_slot[22:19], cursor_present[23]
	input  logic [spdlq_pkg::IN_W-1:0]   s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// success[0], result_slot[4:1], slot_found[5], frame_out[21:6],
	// tx_used[26:22], rx_used[31:27], slots_free[36:32], zero fill above
	output logic [spdlq_pkg::OUT_W-1:0]  m_tdata
);
	import spdlq_pkg::*;

	in_item_t            in_item;
	result_t             res;
	result_t             out_q;
	logic                res_valid;
	logic                out_free;
	logic                m_tvalid_q;
	flag_cmd_t           flag_cmd;
	flag_view_t          flags;
	frame_port_t         frame_port;
	link_port_t          next_port;
	link_port_t          prev_port;
	logic [HANDLE_W-1:0] frame_rd;
	logic [SLOT_W-1:0]   next_rd;
	logic [SLOT_W-1:0]   prev_rd;

	assign in_item  = s_tdata[$bits(in_item_t)-1:0];
	assign out_free = !m_tvalid_q || m_tready;

	spdlq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res),
		.flags      (flags),
		.flag_cmd   (flag_cmd),
		.frame_port (frame_port),
		.frame_rd   (frame_rd),
		.next_port  (next_port),
		.next_rd    (next_rd),
		.prev_port  (prev_port),
		.prev_rd    (prev_rd)
	);

	spdlq_flags u_flags (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (flag_cmd),
		.view   (flags)
	);

	spdlq_ram #(.WIDTH(HANDLE_W), .DEPTH(POOL_SLOTS)) u_frame_ram (
		.clk   (clk),
		.we    (frame_port.we),
		.waddr (frame_port.waddr),
		.wdata (frame_port.wdata),
		.re    (frame_port.re),
		.raddr (frame_port.raddr),
		.rdata (frame_rd)
	);

	spdlq_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_next_ram (
		.clk   (clk),
		.we    (next_port.we),
		.waddr (next_port.waddr),
		.wdata (next_port.wdata),
		.re    (next_port.re),
		.raddr (next_port.raddr),
		.rdata (next_rd)
	);

	spdlq_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_prev_ram (
		.clk   (clk),
		.we    (prev_port.we),
		.waddr (prev_port.waddr),
		.wdata (prev_port.wdata),
		.re    (prev_port.re),
		.raddr (prev_port.raddr),
		.rdata (prev_rd)
	);

	// output register: hold a result until the downstream transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_W - $bits(result_t))'(0), out_q};

endmodule

// ===== hw/rtl/spdlq_checker.sv =====
// Port-level checks for the shared-pool dual-list queue and the bind that
// attaches them to the top level. Depends on spdlq_pkg.
module spdlq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [spdlq_pkg::OUT_W-1:0]  m_tdata
);
	import spdlq_pkg::*;

	result_t res;

	assign res = m_tdata[$bits(result_t)-1:0];

	// counts and free slots always add up to the pool size
	a_pool_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((CNT_W + 1)'(res.tx_used) + (CNT_W + 1)'(res.rx_used)
			+ (CNT_W + 1)'(res.slots_free)) == (CNT_W + 1)'(POOL_SLOTS))
		else $error("list counts and free slots do not sum to the pool size");

	// a returned slot is always a successful lookup
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.slot_found) |-> res.success)
		else $error("slot reported found without success");

	// one operation at a time: no input taken right after an accepted one
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an operation is in progress");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

endmodule

bind shared_pool_dual_list_queue spdlq_checker u_spdlq_checker (.*);

// ===== tb/list_queue_checker.sv =====
// Checker for the shared-pool dual-list queue: watches both stream channels,
// predicts each result from its own copy of the pool and lists, and compares.
// Depends on spdlq_pkg.
module list_queue_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [spdlq_pkg::IN_W-1:0]  s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [spdlq_pkg::OUT_W-1:0] m_tdata,
	output int                          mismatches,
	output int                          outstanding
);
	import spdlq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// mirrored pool and list state
	logic [HANDLE_W-1:0] slot_handle [POOL_SLOTS];
	logic                slot_used   [POOL_SLOTS];
	logic                slot_rx     [POOL_SLOTS];
	logic [SLOT_W-1:0]   link_next   [POOL_SLOTS];
	logic [SLOT_W-1:0]   link_prev   [POOL_SLOTS];
	logic                link_valid  [POOL_SLOTS];
	int                  head_tx, head_rx;
	int                  count_tx, count_rx;

	result_t expected_results [$];
	int      fail_cnt;

	// Apply one operation to the mirrored lists and return its result.
	function automatic result_t apply_list_op(in_item_t it);
		result_t    res;
		logic [2:0] md;
		logic       rx, hn, cur_ok;
		int         s, i, c, hd, nx, pv, cnt;
		res    = '0;
		md     = it.mode;
		c      = int'(it.cursor_slot);
		cur_ok = it.cursor_present && slot_used[c];
		case (md)
			MODE_PUSH_TX, MODE_PUSH_RX: begin
				// take the lowest free slot and link it in front of the head
				s = -1;
				for (i = POOL_SLOTS - 1; i >= 0; i--)
					if (!slot_used[i])
						s = i;
				if (s >= 0) begin
					rx = (md == MODE_PUSH_RX);
					cnt = rx ? count_rx : count_tx;
					hd  = rx ? head_rx : head_tx;
					slot_handle[s] = it.frame_handle;
					slot_used[s]   = 1'b1;
					slot_rx[s]     = rx;
					if (cnt != 0) begin
						link_next[s]  = SLOT_W'(hd);
						link_valid[s] = 1'b1;
						link_prev[hd] = SLOT_W'(s);
					end else begin
						link_next[s]  = '0;
						link_valid[s] = 1'b0;
					end
					if (rx) begin
						head_rx = s;
						count_rx++;
					end else begin
						head_tx = s;
						count_tx++;
					end
					res.success = 1'b1;
				end
			end
			MODE_FIRST_TX, MODE_FIRST_RX: begin
				cnt = (md == MODE_FIRST_RX) ? count_rx : count_tx;
				hd  = (md == MODE_FIRST_RX) ? head_rx : head_tx;
				if (cnt != 0) begin
					res.success     = 1'b1;
					res.slot_found  = 1'b1;
					res.result_slot = SLOT_W'(hd);
					res.frame_out   = slot_handle[hd];
				end
			end
			MODE_NEXT: begin
				if (cur_ok && link_valid[c]) begin
					res.success     = 1'b1;
					res.slot_found  = 1'b1;
					res.result_slot = link_next[c];
					res.frame_out   = slot_handle[link_next[c]];
				end
			end
			MODE_REMOVE: begin
				// unlink the slot from whichever list owns it and free it
				if (cur_ok) begin
					res.frame_out = slot_handle[c];
					rx = slot_rx[c];
					hd = rx ? head_rx : head_tx;
					hn = link_valid[c];
					nx = int'(link_next[c]);
					pv = int'(link_prev[c]);
					if (hd == c) begin
						hd = hn ? nx : 0;
					end else begin
						link_next[pv]  = SLOT_W'(nx);
						link_valid[pv] = hn;
					end
					if (hn)
						link_prev[nx] = SLOT_W'((hd == nx) ? 0 : pv);
					slot_used[c]  = 1'b0;
					slot_rx[c]    = 1'b0;
					link_valid[c] = 1'b0;
					if (rx) begin
						head_rx = hd;
						if (count_rx != 0)
							count_rx--;
					end else begin
						head_tx = hd;
						if (count_tx != 0)
							count_tx--;
					end
					res.success = 1'b1;
				end
			end
			MODE_READ: begin
				if (cur_ok) begin
					res.success   = 1'b1;
					res.frame_out = slot_handle[c];
				end
			end
			default: ;
		endcase
		res.tx_used    = CNT_W'(count_tx);
		res.rx_used    = CNT_W'(count_rx);
		res.slots_free = CNT_W'(POOL_SLOTS - count_tx - count_rx);
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
			fail_cnt++;
		end
	endtask

	// Track transactions on both channels; compare results against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < POOL_SLOTS; i++) begin
				slot_handle[i] = '0;
				slot_used[i]   = 1'b0;
				slot_rx[i]     = 1'b0;
				link_next[i]   = '0;
				link_prev[i]   = '0;
				link_valid[i]  = 1'b0;
			end
			head_tx  = 0;
			head_rx  = 0;
			count_tx = 0;
			count_rx = 0;
			fail_cnt = 0;
			expected_results.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, got);
					fail_cnt++;
				end else begin
					want = expected_results.pop_front();
					check_field("success", 32'(want.success), 32'(got.success));
					check_field("result_slot", 32'(want.result_slot),
						32'(got.result_slot));
					check_field("slot_found", 32'(want.slot_found), 32'(got.slot_found));
					check_field("frame_out", 32'(want.frame_out), 32'(got.frame_out));
					check_field("tx_used", 32'(want.tx_used), 32'(got.tx_used));
					check_field("rx_used", 32'(want.rx_used), 32'(got.rx_used));
					check_field("slots_free", 32'(want.slots_free), 32'(got.slots_free));
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(
					apply_list_op(in_item_t'(s_tdata[$bits(in_item_t)-1:0])));
			mismatches  <= fail_cnt;
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== tb/shared_pool_dual_list_queue_test.sv =====
// Top of the shared-pool dual-list queue testbench: clock, reset, directed and
// random operation stimulus, receiver back-pressure and the verdict.
// Depends on spdlq_pkg, shared_pool_dual_list_queue and list_queue_checker.
module shared_pool_dual_list_queue_test;
	import spdlq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] MODE_UNUSED  = 3'd7;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         SEGMENTS     = 15;
	localparam int         SEGMENT_LEN  = 50;

	logic             clk;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	int               mismatches;
	int               outstanding;
	int               sent_count = 0;
	int               cycles     = 0;

	shared_pool_dual_list_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	list_queue_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one transaction, with random idle cycles ahead of it, and hold until accepted.
	task automatic offer_op(input logic [2:0] md, input logic [HANDLE_W-1:0] fh,
			input logic [SLOT_W-1:0] cs, input logic cp);
		while (!(sent_count >= 300 && sent_count < 420) && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({cp, cs, fh, md});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_count++;
	endtask

	// Receiver: random stalls, one long hold-off so the pool backs up, one steady stretch.
	initial begin
		int rcyc;
		rcyc = 0;
		forever begin
			@(posedge clk);
			rcyc++;
			if (rcyc >= 1000 && rcyc < 1400)
				m_tready <= 1'b0;
			else if (rcyc >= 1800 && rcyc < 2600)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= 16);
		end
	end

	// Abort on a hung run.
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int         r, push_w, drop_w;
		logic [2:0] md;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty lists, null cursors, free-slot cursors and the unused mode
		offer_op(MODE_FIRST_TX, 16'h0000, 4'd0, 1'b0);
		offer_op(MODE_FIRST_RX, 16'h0000, 4'd0, 1'b0);
		offer_op(MODE_NEXT, 16'h1234, 4'd0, 1'b0);
		offer_op(MODE_REMOVE, 16'h0000, 4'd0, 1'b0);
		offer_op(MODE_READ, 16'h0000, 4'd0, 1'b0);
		offer_op(MODE_READ, 16'h0000, 4'd3, 1'b1);
		offer_op(MODE_NEXT, 16'h0000, 4'd9, 1'b1);
		offer_op(MODE_UNUSED, 16'h0000, 4'd0, 1'b0);
		// build tx list 3 -> 1 -> 0 and rx list 2
		offer_op(MODE_PUSH_TX, 16'hFFFF, 4'd0, 1'b0);
		offer_op(MODE_PUSH_TX, 16'h0000, 4'd15, 1'b1);
		offer_op(MODE_PUSH_RX, 16'hA5A5, 4'd0, 1'b0);
		offer_op(MODE_PUSH_TX, 16'h5A5A, 4'd0, 1'b0);
		offer_op(MODE_FIRST_TX, 16'h0000, 4'd0, 1'b0);
		offer_op(MODE_FIRST_RX, 16'h0000, 4'd0, 1'b0);
		// walk to the end of the tx list
		offer_op(MODE_NEXT, 16'h0000, 4'd3, 1'b1);
		offer_op(MODE_NEXT, 16'h0000, 4'd1, 1'b1);
		offer_op(MODE_NEXT, 16'h0000, 4'd0, 1'b1);
		offer_op(MODE_READ, 16'h0000, 4'd2, 1'b1);
		// unlink middle, then heads, then the last entry
		offer_op(MODE_REMOVE, 16'h0000, 4'd1, 1'b1);
		offer_op(MODE_NEXT, 16'h0000, 4'd3, 1'b1);
		offer_op(MODE_REMOVE, 16'h0000, 4'd2, 1'b1);
		offer_op(MODE_FIRST_RX, 16'h0000, 4'd0, 1'b0);
		offer_op(MODE_REMOVE, 16'h0000, 4'd3, 1'b1);
		offer_op(MODE_REMOVE, 16'h0000, 4'd0, 1'b1);
		offer_op(MODE_UNUSED, 16'hFFFF, 4'd15, 1'b1);

		// random segments that fill, churn or drain the pool
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case ($urandom_range(2))
				0: begin push_w = 70; drop_w = 10; end
				1: begin push_w = 35; drop_w = 35; end
				default: begin push_w = 10; drop_w = 60; end
			endcase
			for (int k = 0; k < SEGMENT_LEN; k++) begin
				r = $urandom_range(99);
				if (r < push_w)
					md = $urandom_range(1) ? MODE_PUSH_RX : MODE_PUSH_TX;
				else if (r < push_w + drop_w)
					md = MODE_REMOVE;
				else if (r == 99)
					md = MODE_UNUSED;
				else begin
					case ($urandom_range(3))
						0: md = MODE_FIRST_TX;
						1: md = MODE_FIRST_RX;
						2: md = MODE_NEXT;
						default: md = MODE_READ;
					endcase
				end
				offer_op(md, HANDLE_W'($urandom_range(65535)), SLOT_W'($urandom_range(15)),
					$urandom_range(9) != 0);
			end
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then settle
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/spdlq_pkg.sv
hw/rtl/spdlq_ram.sv
hw/rtl/spdlq_flags.sv
hw/rtl/spdlq_ctrl.sv
hw/rtl/shared_pool_dual_list_queue.sv
hw/rtl/spdlq_checker.sv
tb/list_queue_checker.sv
tb/shared_pool_dual_list_queue_test.sv
